@@ design/dsvl_pkg.sv @@
// ----------------------------------------------------------------------------
// dsvl_pkg
// Shared types, constants and helpers of the dual-screen viewport layout.
// ----------------------------------------------------------------------------
package dsvl_pkg;

  localparam int COORD_BITS = 13;
  localparam int DIM_W      = 13;
  localparam int REG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int DEN_W      = REG_W + 1;
  localparam int PROD_W     = DIM_W + REG_W + 1;
  localparam int NUM_W      = 37;
  localparam int VAL_W      = NUM_W + 3;
  localparam int IN_DATA_W  = ((2 * DIM_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((8 * COORD_BITS + 7) / 8) * 8;

  localparam logic [REG_W-1:0] RST_UPPER_W = REG_W'(400);
  localparam logic [REG_W-1:0] RST_UPPER_H = REG_W'(240);
  localparam logic [REG_W-1:0] RST_LOWER_W = REG_W'(320);
  localparam logic [REG_W-1:0] RST_LOWER_H = REG_W'(240);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_W = 2'd0,
    REG_UPPER_H = 2'd1,
    REG_LOWER_W = 2'd2,
    REG_LOWER_H = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LAY_STACK  = 2'd0,
    LAY_SINGLE = 2'd1,
    LAY_LARGE  = 2'd2
  } layout_t;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t COORD_MAX = val_t'((1 << COORD_BITS) - 1);

  typedef struct packed {
    logic [REG_W-1:0] tw;
    logic [REG_W-1:0] th;
    logic [REG_W-1:0] bw;
    logic [REG_W-1:0] bh;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    layout_t          mode;
    logic             swap;
    logic             cond;
    logic             neg;
    val_t             v1;
  } ctx_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] den;
  } div_st_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] up_l;
    logic [COORD_BITS-1:0] up_r;
    logic [COORD_BITS-1:0] up_t;
    logic [COORD_BITS-1:0] up_b;
    logic [COORD_BITS-1:0] lo_l;
    logic [COORD_BITS-1:0] lo_r;
    logic [COORD_BITS-1:0] lo_t;
    logic [COORD_BITS-1:0] lo_b;
    logic                  up_shown;
    logic                  lo_shown;
  } res_t;

  // one restoring division step, one quotient bit
  function automatic div_st_t div_step(div_st_t s);
    logic [DEN_W:0] t;
    logic           ge;
    div_st_t        o;
    t     = {s.rem, s.nq[NUM_W-1]};
    ge    = (t >= {1'b0, s.den});
    o.den = s.den;
    o.rem = ge ? DEN_W'(t - {1'b0, s.den}) : t[DEN_W-1:0];
    o.nq  = {s.nq[NUM_W-2:0], ge};
    return o;
  endfunction

  function automatic val_t to_val(logic [NUM_W-1:0] x);
    return $signed(VAL_W'(x));
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_coord(val_t v);
    if (v < 0) begin
      return '0;
    end else if (v > COORD_MAX) begin
      return '1;
    end
    return v[COORD_BITS-1:0];
  endfunction

  // primary screen: the upper one unless swapped (stacked always uses upper)
  function automatic logic [REG_W-1:0] prim_w(cfg_t c, layout_t m, logic s);
    return (m != LAY_STACK && s) ? c.bw : c.tw;
  endfunction

  function automatic logic [REG_W-1:0] prim_h(cfg_t c, layout_t m, logic s);
    return (m != LAY_STACK && s) ? c.bh : c.th;
  endfunction

  function automatic logic [REG_W-1:0] side_w(cfg_t c, logic s);
    return s ? c.tw : c.bw;
  endfunction

  function automatic logic [REG_W-1:0] side_h(cfg_t c, logic s);
    return s ? c.th : c.bh;
  endfunction

endpackage

@@ design/dsvl_front.sv @@
// ----------------------------------------------------------------------------
// dsvl_front
// Input clamp, aspect products and cross-multiplied compare; sets up the
// first division.
// ----------------------------------------------------------------------------
module dsvl_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  dsvl_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  input  logic [dsvl_pkg::DIM_W-1:0]   w_in,
  input  logic [dsvl_pkg::DIM_W-1:0]   h_in,
  input  logic [1:0]                   mode_in,
  input  logic                         swap_in,
  output logic                         out_valid,
  output logic [dsvl_pkg::NUM_W-1:0]   num,
  output logic [dsvl_pkg::DEN_W-1:0]   den,
  output dsvl_pkg::ctx_t               ctx
);

  logic                              a_vld;
  logic [dsvl_pkg::DIM_W-1:0]        a_w;
  logic [dsvl_pkg::DIM_W-1:0]        a_h;
  dsvl_pkg::layout_t                 a_mode;
  logic                              a_swap;
  logic [dsvl_pkg::PROD_W-1:0]       a_pa;
  logic [dsvl_pkg::PROD_W-1:0]       a_pb;
  logic signed [dsvl_pkg::PROD_W:0]  a_pc;

  logic [dsvl_pkg::DIM_W-1:0]        w_c;
  logic [dsvl_pkg::DIM_W-1:0]        h_c;
  dsvl_pkg::layout_t                 mode_c;
  logic [dsvl_pkg::REG_W-1:0]        pw_c;
  logic [dsvl_pkg::REG_W-1:0]        ph_c;
  logic signed [dsvl_pkg::DIM_W:0]   diff_c;
  logic signed [dsvl_pkg::PROD_W:0]  diff_x;
  logic signed [dsvl_pkg::PROD_W:0]  ph_x;

  logic [dsvl_pkg::REG_W-1:0]        pw_b;
  logic [dsvl_pkg::REG_W-1:0]        ph_b;
  logic signed [dsvl_pkg::PROD_W:0]  mag_b;
  logic                              cond_b;
  logic                              neg_b;
  logic [dsvl_pkg::NUM_W-1:0]        num_b;
  logic [dsvl_pkg::DEN_W-1:0]        den_b;

  always_comb begin
    w_c = (w_in == '0) ? dsvl_pkg::DIM_W'(1) : w_in;
    h_c = (h_in == '0) ? dsvl_pkg::DIM_W'(1) : h_in;
    case (mode_in)
      dsvl_pkg::LAY_SINGLE: mode_c = dsvl_pkg::LAY_SINGLE;
      dsvl_pkg::LAY_LARGE:  mode_c = dsvl_pkg::LAY_LARGE;
      default:              mode_c = dsvl_pkg::LAY_STACK;
    endcase
    pw_c   = dsvl_pkg::prim_w(cfg, mode_c, swap_in);
    ph_c   = dsvl_pkg::prim_h(cfg, mode_c, swap_in);
    diff_c = $signed({1'b0, w_c}) - $signed({2'b00, dsvl_pkg::side_w(cfg, swap_in)});
    diff_x = (dsvl_pkg::PROD_W + 1)'(diff_c);
    ph_x   = $signed((dsvl_pkg::PROD_W + 1)'(ph_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_w    <= w_c;
      a_h    <= h_c;
      a_mode <= mode_c;
      a_swap <= swap_in;
      a_pa   <= dsvl_pkg::PROD_W'(h_c) * dsvl_pkg::PROD_W'(pw_c);
      a_pb   <= dsvl_pkg::PROD_W'(w_c) * dsvl_pkg::PROD_W'(ph_c);
      a_pc   <= diff_x * ph_x;
    end
  end

  always_comb begin
    pw_b   = dsvl_pkg::prim_w(cfg, a_mode, a_swap);
    ph_b   = dsvl_pkg::prim_h(cfg, a_mode, a_swap);
    mag_b  = (a_pc < 0) ? -a_pc : a_pc;
    cond_b = 1'b0;
    neg_b  = 1'b0;
    case (a_mode)
      dsvl_pkg::LAY_SINGLE: begin
        cond_b = (a_pa > a_pb);
        num_b  = cond_b ? dsvl_pkg::NUM_W'(a_pb) : dsvl_pkg::NUM_W'(a_pa);
        den_b  = cond_b ? dsvl_pkg::DEN_W'(pw_b) : dsvl_pkg::DEN_W'(ph_b);
      end
      dsvl_pkg::LAY_LARGE: begin
        neg_b = (a_pc < 0);
        num_b = dsvl_pkg::NUM_W'(mag_b);
        den_b = dsvl_pkg::DEN_W'(pw_b);
      end
      default: begin
        cond_b = ({1'b0, a_pa} > {a_pb, 1'b0});
        num_b  = cond_b ? dsvl_pkg::NUM_W'({a_pb, 1'b0}) : dsvl_pkg::NUM_W'(a_pa);
        den_b  = cond_b ? dsvl_pkg::DEN_W'(cfg.tw) : dsvl_pkg::DEN_W'({cfg.th, 1'b0});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num      <= num_b;
      den      <= den_b;
      ctx.w    <= a_w;
      ctx.h    <= a_h;
      ctx.mode <= a_mode;
      ctx.swap <= a_swap;
      ctx.cond <= cond_b;
      ctx.neg  <= neg_b;
      ctx.v1   <= '0;
    end
  end

endmodule

@@ design/dsvl_div.sv @@
// ----------------------------------------------------------------------------
// dsvl_div
// Pipelined restoring divider, one quotient bit per stage, context carried
// alongside.
// ----------------------------------------------------------------------------
module dsvl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [dsvl_pkg::NUM_W-1:0]  num,
  input  logic [dsvl_pkg::DEN_W-1:0]  den,
  input  dsvl_pkg::ctx_t              in_ctx,
  output logic                        out_valid,
  output logic [dsvl_pkg::NUM_W-1:0]  quo,
  output logic [dsvl_pkg::DEN_W-1:0]  rem,
  output logic [dsvl_pkg::DEN_W-1:0]  div_den,
  output dsvl_pkg::ctx_t              out_ctx
);

  logic [dsvl_pkg::NUM_W-1:0] vld;
  dsvl_pkg::div_st_t          st [dsvl_pkg::NUM_W];
  dsvl_pkg::ctx_t             cx [dsvl_pkg::NUM_W];
  dsvl_pkg::div_st_t          seed;

  always_comb begin
    seed.rem = '0;
    seed.nq  = num;
    seed.den = den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[dsvl_pkg::NUM_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= dsvl_pkg::div_step(seed);
      cx[0] <= in_ctx;
      for (int i = 1; i < dsvl_pkg::NUM_W; i++) begin
        st[i] <= dsvl_pkg::div_step(st[i-1]);
        cx[i] <= cx[i-1];
      end
    end
  end

  assign out_valid = vld[dsvl_pkg::NUM_W-1];
  assign quo       = st[dsvl_pkg::NUM_W-1].nq;
  assign rem       = st[dsvl_pkg::NUM_W-1].rem;
  assign div_den   = st[dsvl_pkg::NUM_W-1].den;
  assign out_ctx   = cx[dsvl_pkg::NUM_W-1];

endmodule

@@ design/dsvl_mid.sv @@
// ----------------------------------------------------------------------------
// dsvl_mid
// Rounds the first quotient and sets up the second division.
// ----------------------------------------------------------------------------
module dsvl_mid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  dsvl_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  input  logic [dsvl_pkg::NUM_W-1:0]  quo,
  input  logic [dsvl_pkg::DEN_W-1:0]  rem,
  input  logic [dsvl_pkg::DEN_W-1:0]  div_den,
  input  dsvl_pkg::ctx_t              in_ctx,
  output logic                        out_valid,
  output logic [dsvl_pkg::NUM_W-1:0]  num,
  output logic [dsvl_pkg::DEN_W-1:0]  den,
  output dsvl_pkg::ctx_t              ctx
);

  logic                         a_vld;
  dsvl_pkg::ctx_t               a_ctx;
  dsvl_pkg::ctx_t               ctx_c;
  dsvl_pkg::val_t               rnd;
  logic                         up_c;
  logic [dsvl_pkg::PROD_W-1:0]  span;
  logic [dsvl_pkg::NUM_W-1:0]   num_b;
  logic [dsvl_pkg::DEN_W-1:0]   den_b;

  always_comb begin
    up_c     = ({rem, 1'b0} >= {1'b0, div_den});
    rnd      = dsvl_pkg::to_val(quo) + dsvl_pkg::to_val(dsvl_pkg::NUM_W'(up_c));
    ctx_c    = in_ctx;
    ctx_c.v1 = in_ctx.neg ? -rnd : rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctx <= ctx_c;
    end
  end

  always_comb begin
    span = a_ctx.cond ? dsvl_pkg::PROD_W'(a_ctx.w) : a_ctx.v1[dsvl_pkg::PROD_W-1:0];
    case (a_ctx.mode)
      dsvl_pkg::LAY_SINGLE: begin
        num_b = '0;
        den_b = dsvl_pkg::DEN_W'(1);
      end
      dsvl_pkg::LAY_LARGE: begin
        num_b = dsvl_pkg::NUM_W'(a_ctx.h) *
                dsvl_pkg::NUM_W'(dsvl_pkg::prim_w(cfg, a_ctx.mode, a_ctx.swap));
        den_b = dsvl_pkg::DEN_W'(dsvl_pkg::prim_h(cfg, a_ctx.mode, a_ctx.swap));
      end
      default: begin
        num_b = dsvl_pkg::NUM_W'(cfg.bw) * dsvl_pkg::NUM_W'(span);
        den_b = dsvl_pkg::DEN_W'(cfg.tw);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= num_b;
      den <= den_b;
      ctx <= a_ctx;
    end
  end

endmodule

@@ design/dsvl_back.sv @@
// ----------------------------------------------------------------------------
// dsvl_back
// Edge terms, rectangle assembly per mode, swap mapping and saturation.
// ----------------------------------------------------------------------------
module dsvl_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  dsvl_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  input  logic [dsvl_pkg::NUM_W-1:0]  quo,
  input  logic [dsvl_pkg::DEN_W-1:0]  rem,
  input  logic [dsvl_pkg::DEN_W-1:0]  div_den,
  input  dsvl_pkg::ctx_t              in_ctx,
  output logic                        out_valid,
  output dsvl_pkg::res_t              res
);

  // stage a
  logic            a_vld;
  dsvl_pkg::ctx_t  a_ctx;
  logic            a_letter;
  dsvl_pkg::val_t  a_a, a_b, a_c, a_d, a_e, a_f;

  dsvl_pkg::val_t  wv, hv, v1, q2, rnd2, half_w, half_h, span, swv;
  logic            up_c;
  logic            letter_c;
  dsvl_pkg::val_t  ta, tb, tc, td, te, tf;

  // stage b
  logic            b_vld;
  logic            b_ushow, b_lshow;
  dsvl_pkg::val_t  b_up [4];
  dsvl_pkg::val_t  b_lo [4];

  dsvl_pkg::val_t  aw, ah, av1, asw, ash, aow, aoh, pr;
  dsvl_pkg::val_t  p [4];
  dsvl_pkg::val_t  s [4];
  dsvl_pkg::val_t  up_n [4];
  dsvl_pkg::val_t  lo_n [4];
  logic            ushow_n, lshow_n;

  always_comb begin
    wv     = dsvl_pkg::to_val(dsvl_pkg::NUM_W'(in_ctx.w));
    hv     = dsvl_pkg::to_val(dsvl_pkg::NUM_W'(in_ctx.h));
    v1     = in_ctx.v1;
    q2     = dsvl_pkg::to_val(quo);
    up_c   = ({rem, 1'b0} >= {1'b0, div_den});
    rnd2   = q2 + dsvl_pkg::to_val(dsvl_pkg::NUM_W'(up_c));
    swv    = dsvl_pkg::to_val(dsvl_pkg::NUM_W'(dsvl_pkg::side_w(cfg, in_ctx.swap)));
    half_w = (wv - v1) >>> 1;
    half_h = (hv - v1) >>> 1;
    span   = in_ctx.cond ? wv : v1;
    letter_c = (v1 == 0) || ((v1 > 0) && (v1 < hv));
    ta = '0;
    tb = '0;
    tc = '0;
    td = '0;
    te = '0;
    tf = '0;
    case (in_ctx.mode)
      dsvl_pkg::LAY_SINGLE: begin
        ta = in_ctx.cond ? half_h : half_w;
      end
      dsvl_pkg::LAY_LARGE: begin
        ta = half_h;
        tb = (wv - swv - rnd2) >>> 1;
        tc = q2;
      end
      default: begin
        ta = in_ctx.cond ? '0 : half_w;
        tb = span;
        tc = in_ctx.cond ? half_h : '0;
        td = in_ctx.cond ? (v1 >>> 1) : (hv >>> 1);
        te = (span - q2) >>> 1;
        tf = q2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctx    <= in_ctx;
      a_letter <= letter_c;
      a_a      <= ta;
      a_b      <= tb;
      a_c      <= tc;
      a_d      <= td;
      a_e      <= te;
      a_f      <= tf;
    end
  end

  always_comb begin
    aw  = dsvl_pkg::to_val(dsvl_pkg::NUM_W'(a_ctx.w));
    ah  = dsvl_pkg::to_val(dsvl_pkg::NUM_W'(a_ctx.h));
    av1 = a_ctx.v1;
    asw = dsvl_pkg::to_val(dsvl_pkg::NUM_W'(dsvl_pkg::side_w(cfg, a_ctx.swap)));
    ash = dsvl_pkg::to_val(dsvl_pkg::NUM_W'(dsvl_pkg::side_h(cfg, a_ctx.swap)));
    aow = asw;
    aoh = ash;
    pr  = a_c + a_b;
    ushow_n = 1'b1;
    lshow_n = 1'b1;
    for (int i = 0; i < 4; i++) begin
      p[i]    = '0;
      s[i]    = '0;
      up_n[i] = '0;
      lo_n[i] = '0;
    end
    case (a_ctx.mode)
      dsvl_pkg::LAY_SINGLE: begin
        if (a_ctx.cond) begin
          p[0] = '0;
          p[1] = aw;
          p[2] = a_a;
          p[3] = a_a + av1;
        end else begin
          p[0] = a_a;
          p[1] = a_a + av1;
          p[2] = '0;
          p[3] = ah;
        end
        s[0] = '0;
        s[1] = aow;
        s[2] = '0;
        s[3] = aoh;
        ushow_n = ~a_ctx.swap;
        lshow_n = a_ctx.swap;
      end
      dsvl_pkg::LAY_LARGE: begin
        if (a_letter) begin
          p[0] = '0;
          p[1] = aw - asw;
          p[2] = a_a;
          p[3] = a_a + av1;
          s[0] = aw - asw;
          s[1] = aw;
          s[2] = a_a + av1 - ash;
          s[3] = a_a + av1;
        end else begin
          p[0] = a_b;
          p[1] = pr;
          p[2] = '0;
          p[3] = ah;
          s[0] = pr;
          s[1] = pr + asw;
          s[2] = ah - ash;
          s[3] = ah;
        end
      end
      default: begin
        // p: first (top) band, s: second band; x extents fixed per screen
        p[0] = a_a;
        p[1] = a_a + a_b;
        p[2] = a_c;
        p[3] = a_c + a_d;
        s[0] = a_a + a_e;
        s[1] = a_a + a_e + a_f;
        s[2] = a_c + a_d;
        s[3] = a_c + a_d + a_d;
      end
    endcase
    if (a_ctx.mode == dsvl_pkg::LAY_SINGLE || a_ctx.mode == dsvl_pkg::LAY_LARGE) begin
      for (int i = 0; i < 4; i++) begin
        up_n[i] = a_ctx.swap ? s[i] : p[i];
        lo_n[i] = a_ctx.swap ? p[i] : s[i];
      end
    end else begin
      up_n[0] = p[0];
      up_n[1] = p[1];
      lo_n[0] = s[0];
      lo_n[1] = s[1];
      up_n[2] = a_ctx.swap ? s[2] : p[2];
      up_n[3] = a_ctx.swap ? s[3] : p[3];
      lo_n[2] = a_ctx.swap ? p[2] : s[2];
      lo_n[3] = a_ctx.swap ? p[3] : s[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ushow <= ushow_n;
      b_lshow <= lshow_n;
      for (int i = 0; i < 4; i++) begin
        b_up[i] <= up_n[i];
        b_lo[i] <= lo_n[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.up_l     <= dsvl_pkg::sat_coord(b_up[0]);
      res.up_r     <= dsvl_pkg::sat_coord(b_up[1]);
      res.up_t     <= dsvl_pkg::sat_coord(b_up[2]);
      res.up_b     <= dsvl_pkg::sat_coord(b_up[3]);
      res.lo_l     <= dsvl_pkg::sat_coord(b_lo[0]);
      res.lo_r     <= dsvl_pkg::sat_coord(b_lo[1]);
      res.lo_t     <= dsvl_pkg::sat_coord(b_lo[2]);
      res.lo_b     <= dsvl_pkg::sat_coord(b_lo[3]);
      res.up_shown <= b_ushow;
      res.lo_shown <= b_lshow;
    end
  end

endmodule

@@ design/dual_screen_viewport_layout_top.sv @@
// ----------------------------------------------------------------------------
// dual_screen_viewport_layout_top
// Places the upper and lower source screens into a window for the stacked,
// single and large-plus-small layouts.
// ----------------------------------------------------------------------------
// Pipeline: front, first divider, mid, second divider, back and the output
//   register; each 37-bit divider is 37 registered one-quotient-bit stages.
// Throughput: one transaction per cycle unless stalled by the skid entry.
// Reset: synchronous rst clears all valid bits and the output/skid stage and
//   loads the screen size registers with 400x240 (upper) and 320x240 (lower).
// ----------------------------------------------------------------------------
module dual_screen_viewport_layout_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dsvl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsvl_pkg::REG_W-1:0]        cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // window_width, window_height
  input  logic [dsvl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // layout_mode, swap_screens
  input  logic [2:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // upper_left, upper_right, upper_top, upper_bottom,
  // lower_left, lower_right, lower_top, lower_bottom
  output logic [dsvl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // upper_shown, lower_shown
  output logic [1:0]                        m_axis_tuser
);

  logic [dsvl_pkg::REG_W-1:0] upper_w, upper_h, lower_w, lower_h;
  dsvl_pkg::cfg_t             cfg;

  logic                       en;
  logic                       f_vld, d1_vld, m_vld, d2_vld, bk_vld;
  logic [dsvl_pkg::NUM_W-1:0] f_num, d1_quo, m_num, d2_quo;
  logic [dsvl_pkg::DEN_W-1:0] f_den, d1_rem, d1_den, m_den, d2_rem, d2_den;
  dsvl_pkg::ctx_t             f_ctx, d1_ctx, m_ctx, d2_ctx;
  dsvl_pkg::res_t             bk_res;

  logic                       push;
  logic                       out_v;
  logic                       sk_v;
  dsvl_pkg::res_t             out_r;
  dsvl_pkg::res_t             sk_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_w <= dsvl_pkg::RST_UPPER_W;
      upper_h <= dsvl_pkg::RST_UPPER_H;
      lower_w <= dsvl_pkg::RST_LOWER_W;
      lower_h <= dsvl_pkg::RST_LOWER_H;
    end else if (cfg_write) begin
      case (cfg_index)
        dsvl_pkg::REG_UPPER_W: upper_w <= cfg_data;
        dsvl_pkg::REG_UPPER_H: upper_h <= cfg_data;
        dsvl_pkg::REG_LOWER_W: lower_w <= cfg_data;
        dsvl_pkg::REG_LOWER_H: lower_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero size counts as one
  always_comb begin
    cfg.tw = (upper_w == '0) ? dsvl_pkg::REG_W'(1) : upper_w;
    cfg.th = (upper_h == '0) ? dsvl_pkg::REG_W'(1) : upper_h;
    cfg.bw = (lower_w == '0) ? dsvl_pkg::REG_W'(1) : lower_w;
    cfg.bh = (lower_h == '0) ? dsvl_pkg::REG_W'(1) : lower_h;
  end

  assign en            = ~sk_v;
  assign s_axis_tready = en;

  dsvl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .w_in      (s_axis_tdata[dsvl_pkg::DIM_W-1:0]),
    .h_in      (s_axis_tdata[2*dsvl_pkg::DIM_W-1:dsvl_pkg::DIM_W]),
    .mode_in   (s_axis_tuser[1:0]),
    .swap_in   (s_axis_tuser[2]),
    .out_valid (f_vld),
    .num       (f_num),
    .den       (f_den),
    .ctx       (f_ctx)
  );

  dsvl_div u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_vld),
    .num       (f_num),
    .den       (f_den),
    .in_ctx    (f_ctx),
    .out_valid (d1_vld),
    .quo       (d1_quo),
    .rem       (d1_rem),
    .div_den   (d1_den),
    .out_ctx   (d1_ctx)
  );

  dsvl_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (d1_vld),
    .quo       (d1_quo),
    .rem       (d1_rem),
    .div_den   (d1_den),
    .in_ctx    (d1_ctx),
    .out_valid (m_vld),
    .num       (m_num),
    .den       (m_den),
    .ctx       (m_ctx)
  );

  dsvl_div u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m_vld),
    .num       (m_num),
    .den       (m_den),
    .in_ctx    (m_ctx),
    .out_valid (d2_vld),
    .quo       (d2_quo),
    .rem       (d2_rem),
    .div_den   (d2_den),
    .out_ctx   (d2_ctx)
  );

  dsvl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (d2_vld),
    .quo       (d2_quo),
    .rem       (d2_rem),
    .div_den   (d2_den),
    .in_ctx    (d2_ctx),
    .out_valid (bk_vld),
    .res       (bk_res)
  );

  // output register plus skid entry
  assign push = bk_vld & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (~out_v | m_axis_tready) begin
      if (sk_v) begin
        out_v <= 1'b1;
        sk_v  <= 1'b0;
      end else begin
        out_v <= push;
      end
    end else if (push) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (~out_v | m_axis_tready) begin
      out_r <= sk_v ? sk_r : bk_res;
    end else if (push) begin
      sk_r <= bk_res;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = dsvl_pkg::OUT_DATA_W'({out_r.lo_b, out_r.lo_t, out_r.lo_r,
                                                out_r.lo_l, out_r.up_b, out_r.up_t,
                                                out_r.up_r, out_r.up_l});
  assign m_axis_tuser  = {out_r.lo_shown, out_r.up_shown};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> out_v)
    else $error("skid entry held without output entry");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (sk_v && m_axis_tready) |=> out_v)
    else $error("skid entry lost on drain");

  a_stall_captures: assert property (@(posedge clk) disable iff (rst)
    (out_v && !m_axis_tready && push) |=> sk_v)
    else $error("result dropped while output stalled");

endmodule

@@ tb/tb_dual_screen_viewport_layout_top.sv @@
// ----------------------------------------------------------------------------
// tb_dual_screen_viewport_layout_top
// Self-checking bench for the dual-screen viewport layout. Window sizes,
// layout modes and the swap flag are streamed in under several screen size
// settings, with random sender gaps and receiver stalls. Each result is
// compared field by field against an exact integer layout predictor.
// ----------------------------------------------------------------------------
module tb_dual_screen_viewport_layout_top;
  import dsvl_pkg::*;

  localparam int CB         = COORD_BITS;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [CB-1:0] coord[8];
    logic [1:0]    shown;
  } placement_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [2:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  logic [REG_W-1:0] scr_tw, scr_th, scr_bw, scr_bh;
  placement_t       pending_placements[$];
  int               error_count = 0;
  int               items_sent = 0;
  int               results_seen = 0;
  int               stall_pct = 0;
  int               gap_pct = 0;
  int               burst_left = 0;
  int               idle_cycles = 0;
  string            coord_name[8] = '{"upper_left", "upper_right", "upper_top",
    "upper_bottom", "lower_left", "lower_right", "lower_top", "lower_bottom"};

  dual_screen_viewport_layout_top u_top (.*);

  always #10 clk = ~clk;

  function automatic longint fdiv(longint n, longint d);
    if (d <= 0) return 0;
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint rdiv(longint n, longint d);
    if (d <= 0) return 0;
    if (n >= 0) return (2 * n + d) / (2 * d);
    return -((2 * (-n) + d) / (2 * d));
  endfunction

  function automatic logic [CB-1:0] clamp_coord(longint v);
    if (v < 0) return '0;
    if (v > (1 << CB) - 1) return '1;
    return v[CB-1:0];
  endfunction

  function automatic longint nonzero(longint v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic placement_t place_screens(logic [DIM_W-1:0] win_w,
      logic [DIM_W-1:0] win_h, logic [1:0] mode, logic swap);
    longint     w, h, tw, th, bw, bh, pw, ph, sw, sh, vh, vw, x, y, pr;
    longint     left, span, y0, half, bwid, border;
    longint     up[4], lo[4], pr4[4], sr4[4];
    placement_t res;
    w = nonzero(win_w);
    h = nonzero(win_h);
    tw = nonzero(scr_tw);
    th = nonzero(scr_th);
    bw = nonzero(scr_bw);
    bh = nonzero(scr_bh);
    pw = swap ? bw : tw;
    ph = swap ? bh : th;
    sw = swap ? tw : bw;
    sh = swap ? th : bh;
    res.shown = 2'b11;
    if (mode == LAY_SINGLE) begin
      if (h * pw > ph * w) begin
        vh = rdiv(ph * w, pw);
        pr4[0] = 0; pr4[1] = w;
        pr4[2] = fdiv(h - vh, 2); pr4[3] = pr4[2] + vh;
      end else begin
        vw = rdiv(h * pw, ph);
        pr4[0] = fdiv(w - vw, 2); pr4[1] = pr4[0] + vw;
        pr4[2] = 0; pr4[3] = h;
      end
      sr4[0] = 0; sr4[1] = sw; sr4[2] = 0; sr4[3] = sh;
      res.shown = swap ? 2'b10 : 2'b01;
    end else if (mode == LAY_LARGE) begin
      vh = rdiv((w - sw) * ph, pw);
      vw = sw + rdiv(h * pw, ph);
      if (vh == 0 || (vh > 0 && vh < h)) begin
        y = fdiv(h - vh, 2);
        pr4[0] = 0; pr4[1] = w - sw; pr4[2] = y; pr4[3] = y + vh;
        sr4[0] = w - sw; sr4[1] = w; sr4[2] = y + vh - sh; sr4[3] = y + vh;
      end else begin
        x = fdiv(w - vw, 2);
        pr = fdiv(h * pw, ph) + x;
        pr4[0] = x; pr4[1] = pr; pr4[2] = 0; pr4[3] = h;
        sr4[0] = pr; sr4[1] = pr + sw; sr4[2] = h - sh; sr4[3] = h;
      end
    end else begin
      // stacked, also the unused mode code
      if (h * tw > 2 * th * w) begin
        vh = rdiv(2 * th * w, tw);
        left = 0; span = w; y0 = fdiv(h - vh, 2); half = fdiv(vh, 2);
      end else begin
        vw = rdiv(h * tw, 2 * th);
        left = fdiv(w - vw, 2); span = vw; y0 = 0; half = fdiv(h, 2);
      end
      bwid = fdiv(bw * span, tw);
      border = fdiv(span - bwid, 2);
      pr4[0] = left; pr4[1] = left + span;
      sr4[0] = left + border; sr4[1] = left + border + bwid;
      pr4[2] = swap ? y0 + half : y0;
      pr4[3] = swap ? y0 + 2 * half : y0 + half;
      sr4[2] = swap ? y0 : y0 + half;
      sr4[3] = swap ? y0 + half : y0 + 2 * half;
      swap = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      up[i] = swap ? sr4[i] : pr4[i];
      lo[i] = swap ? pr4[i] : sr4[i];
      res.coord[i] = clamp_coord(up[i]);
      res.coord[4+i] = clamp_coord(lo[i]);
    end
    return res;
  endfunction

  // input monitor: predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      pending_placements.push_back(place_screens(s_axis_tdata[DIM_W-1:0],
        s_axis_tdata[2*DIM_W-1:DIM_W], s_axis_tuser[1:0], s_axis_tuser[2]));
    end
  end

  // result checker
  always @(posedge clk) begin
    placement_t exp_p;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (pending_placements.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_axis_tdata,
          m_axis_tuser);
        error_count++;
      end else begin
        exp_p = pending_placements.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (m_axis_tdata[i*CB +: CB] !== exp_p.coord[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, coord_name[i],
              exp_p.coord[i], m_axis_tdata[i*CB +: CB]);
            error_count++;
          end
        end
        if (m_axis_tuser !== exp_p.shown) begin
          $display("%0t: shown flags expected %b actual %b", $time, exp_p.shown,
            m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
          pending_placements.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_window(int win_w, int win_h, int mode, bit swap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({win_h[DIM_W-1:0], win_w[DIM_W-1:0]});
    s_axis_tuser  <= {swap, mode[1:0]};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 99) < gap_pct) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_screen_reg(cfg_reg_t idx, logic [REG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_UPPER_W: scr_tw = val;
      REG_UPPER_H: scr_th = val;
      REG_LOWER_W: scr_bw = val;
      default:     scr_bh = val;
    endcase
  endtask

  task automatic set_screens(int tw, int th, int bw, int bh);
    drain_results();
    write_screen_reg(REG_UPPER_W, tw[REG_W-1:0]);
    write_screen_reg(REG_UPPER_H, th[REG_W-1:0]);
    write_screen_reg(REG_LOWER_W, bw[REG_W-1:0]);
    write_screen_reg(REG_LOWER_H, bh[REG_W-1:0]);
  endtask

  function automatic int rand_dim();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(8188, 8191);
      2:       return $urandom_range(0, 1023);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  task automatic test_directed();
    int dims[4] = '{0, 1, 8191, 400};
    stall_pct = 0;
    gap_pct = 0;
    for (int m = 0; m < 4; m++) begin
      send_window(dims[m], dims[(m + 1) % 4], LAY_STACK, m[0]);
      send_window(dims[(m + 2) % 4], dims[m], LAY_SINGLE, m[1]);
      send_window(dims[m], dims[(m + 3) % 4], LAY_LARGE, !m[0]);
    end
    for (int s = 0; s < 2; s++) begin
      send_window(1280, 960, 3, s);
      send_window(800, 2000, LAY_SINGLE, s);
      send_window(320, 240, LAY_LARGE, s);
      send_window(8191, 8191, LAY_STACK, s);
    end
    send_window(5461, 2730, LAY_SINGLE, 1'b0);
  endtask

  task automatic test_random_windows(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      send_window(rand_dim(), rand_dim(), $urandom_range(0, 3), $urandom_range(0, 1));
    end
  endtask

  task automatic test_screen_settings();
    int pct[6] = '{0, 20, 50, 80, 10, 35};
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: set_screens(RST_UPPER_W, RST_UPPER_H, RST_LOWER_W, RST_LOWER_H);
        1: set_screens(4095, 4095, 4095, 4095);
        2: set_screens(0, 1, 0, 1);
        3: set_screens(4095, 1, 1, 4095);
        default: set_screens($urandom_range(0, 4095), $urandom_range(0, 4095),
          $urandom_range(0, 4095), $urandom_range(0, 4095));
      endcase
      stall_pct = pct[k];
      gap_pct = pct[5 - k];
      test_random_windows(200);
    end
  endtask

  initial begin
    scr_tw = RST_UPPER_W;
    scr_th = RST_UPPER_H;
    scr_bw = RST_LOWER_W;
    scr_bh = RST_LOWER_H;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_screen_settings();
    drain_results();
    repeat (200) @(posedge clk);
    $display("Sent %0d windows over six screen size settings, all four mode codes,",
      items_sent);
    $display("both swap values; %0d results checked.", results_seen);
    if (error_count == 0 && pending_placements.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
